// File: hdl/rob_pkg.sv
// shared constants, codes and field widths of the reorder buffer
package rob_pkg;

    // default sizes
    localparam int ROB_DEPTH = 16;
    localparam int NUM_REGS  = 16;

    // field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 4;
    localparam int REG_W   = 4;
    localparam int CLS_W   = 3;
    localparam int VAL_W   = 64;
    localparam int OUTC_W  = 3;

    // data stream widths, padded to whole bytes
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 152;
    localparam int S_USER_W = OP_W;
    localparam int M_USER_W = OUTC_W;

    // operations
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ    = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
    localparam logic [OP_W-1:0] OP_RETIRE  = 3'd4;

    // instruction classes
    localparam logic [CLS_W-1:0] CLS_NOP    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ALU    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_LOAD   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_STORE  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BRANCH = 3'd4;

    // outcomes
    localparam logic [OUTC_W-1:0] OUTC_DONE     = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_FULL     = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_NONE     = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_GRADUATE = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_RETIRED  = 3'd4;

    // branch target meaning not taken
    localparam logic [VAL_W-1:0] NOT_TAKEN = '1;

    // one result item, before packing
    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [IDX_W-1:0]  out_index;
        logic              is_full;
        logic              reg_write;
        logic [REG_W-1:0]  out_dest;
        logic [VAL_W-1:0]  out_value;
        logic              value_ready;
        logic [VAL_W-1:0]  pc_value;
        logic              clear_mem_status;
        logic              flush_any;
        logic [IDX_W-1:0]  flush_first;
        logic [IDX_W-1:0]  flush_last;
    } t_result;

endpackage

// File: hdl/reorder_buffer_top.sv
// reorder buffer: circular entry store with head, tail, full flag and program counter
// a result item is computed in the execute state from the entry data read on accept
// and lands in the output register when that state fires, which waits while the output
// register is full and not emptied; items are accepted only in the idle state
// reset: synchronous, active low; clears head, tail, full flag, pc and all ready bits
//   at once; the entry memories are not cleared and need no clearing pass
module reorder_buffer_top #(
    parameter int DEPTH = rob_pkg::ROB_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: entry_index[3:0], dest_reg[7:4], op_class[10:8], data_value[74:11], zeros
    input  logic [rob_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [rob_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: out_index[3:0], is_full[4], reg_write[5], out_dest[9:6], out_value[73:10],
    //        value_ready[74], pc_value[138:75], clear_mem_status[139],
    //        flush_any[140], flush_first[144:141], flush_last[148:145], zeros
    output logic [rob_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // tuser: outcome[2:0]
    output logic [rob_pkg::M_USER_W-1:0]  o_m_axis_tuser
);
    import rob_pkg::*;

    // pointer and count widths follow the depth
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = PTR_W + 1;
    localparam int WIDE_W = (PTR_W > IDX_W) ? PTR_W : IDX_W;
    localparam int INFO_W = REG_W + CLS_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // circular pointer helpers
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    // distance from b forward to a, modulo the depth
    function automatic logic [CNT_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b);
        logic [CNT_W-1:0] ea;
        logic [CNT_W-1:0] eb;
        ea = {1'b0, a};
        eb = {1'b0, b};
        return (ea >= eb) ? (ea - eb) : (ea + DEPTH_C - eb);
    endfunction

    // narrow a pointer onto a 4-bit result index
    function automatic logic [IDX_W-1:0] to_index(input logic [PTR_W-1:0] p);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(p);
        return w[IDX_W-1:0];
    endfunction

    // unpacked input fields
    logic [OP_W-1:0]  s_op;
    logic [IDX_W-1:0] s_idx;
    logic [REG_W-1:0] s_dest;
    logic [CLS_W-1:0] s_cls;
    logic [VAL_W-1:0] s_val;
    logic [WIDE_W-1:0] s_idx_wide;
    logic [PTR_W-1:0]  s_rd_addr;

    assign s_op   = i_s_axis_tuser;
    assign s_idx  = i_s_axis_tdata[3:0];
    assign s_dest = i_s_axis_tdata[7:4];
    assign s_cls  = i_s_axis_tdata[10:8];
    assign s_val  = i_s_axis_tdata[74:11];
    assign s_idx_wide = WIDE_W'(s_idx);

    // control state
    logic              r_state;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic              r_full;
    logic [VAL_W-1:0]  r_pc;
    logic [DEPTH-1:0]  r_ready;
    logic              r_m_valid;

    // latched item
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [REG_W-1:0]  r_dest;
    logic [CLS_W-1:0]  r_cls;
    logic [VAL_W-1:0]  r_wval;

    // entry memories and their registered read data
    logic [VAL_W-1:0]  m_value [DEPTH];
    logic [INFO_W-1:0] m_info  [DEPTH];
    logic [VAL_W-1:0]  r_rd_value;
    logic [INFO_W-1:0] r_rd_info;

    // output register
    t_result r_res;

    logic s_accept;
    logic fire;

    // an item enters only while the sequencer is idle
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    // the result is committed once the output register is free or being emptied
    assign fire            = (r_state == S_EXEC) && (!r_m_valid || i_m_axis_tready);

    // a retire reads the head entry, everything else the addressed one
    assign s_rd_addr = (s_op == OP_RETIRE) ? r_head : s_idx_wide[PTR_W-1:0];

    // next-state and result logic of the execute cycle
    logic [WIDE_W-1:0] x_idx_wide;
    logic [PTR_W-1:0]  x_addr;
    logic              x_idx_ok;
    logic [CNT_W-1:0]  x_cnt;
    logic [CNT_W-1:0]  x_dist;
    logic [PTR_W-1:0]  x_first;
    logic [PTR_W-1:0]  x_last;
    logic [CNT_W-1:0]  x_span;
    logic [CLS_W-1:0]  x_cls;
    logic [REG_W-1:0]  x_dest;
    logic              x_info_we;
    logic              x_value_we;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic              n_full;
    logic [VAL_W-1:0]  n_pc;
    logic [DEPTH-1:0]  n_ready;
    t_result           n_res;

    always_comb begin
        x_idx_wide = WIDE_W'(r_idx);
        x_addr     = x_idx_wide[PTR_W-1:0];
        x_idx_ok   = (32'(r_idx) < DEPTH);
        x_cnt      = r_full ? DEPTH_C : ring_dist(r_tail, r_head);
        x_dist     = ring_dist(x_addr, r_head);
        x_first    = next_slot(x_addr);
        x_last     = prev_slot(r_tail);
        x_span     = ring_dist(x_last, x_first);
        x_cls      = r_rd_info[CLS_W-1:0];
        x_dest     = r_rd_info[INFO_W-1:CLS_W];
        x_info_we  = 1'b0;
        x_value_we = 1'b0;

        n_head  = r_head;
        n_tail  = r_tail;
        n_full  = r_full;
        n_pc    = r_pc;
        n_ready = r_ready;
        n_res   = '0;
        n_res.outcome = OUTC_DONE;

        unique case (r_op)
            OP_RESERVE: begin
                if (r_full) begin
                    n_res.outcome = OUTC_FULL;
                end else begin
                    x_info_we         = 1'b1;
                    n_ready[r_tail]   = 1'b0;
                    n_tail            = next_slot(r_tail);
                    n_full            = (next_slot(r_tail) == r_head);
                    n_res.out_index   = to_index(r_tail);
                end
            end
            OP_WRITE: begin
                if (x_idx_ok) begin
                    x_value_we      = 1'b1;
                    n_ready[x_addr] = 1'b1;
                end
            end
            OP_READ: begin
                if (x_idx_ok) begin
                    n_res.out_value   = r_rd_value;
                    n_res.value_ready = r_ready[x_addr];
                end
            end
            OP_FLUSH: begin
                // frees everything younger than the addressed entry, if any
                if (x_idx_ok && (x_dist + 1'b1 < x_cnt)) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ring_dist(PTR_W'(i), x_first) <= x_span) begin
                            n_ready[i] = 1'b0;
                        end
                    end
                    n_tail            = x_first;
                    n_full            = 1'b0;
                    n_res.flush_any   = 1'b1;
                    n_res.flush_first = to_index(x_first);
                    n_res.flush_last  = to_index(x_last);
                end
            end
            OP_RETIRE: begin
                priority if (x_cnt == '0) begin
                    n_res.outcome = OUTC_NONE;
                end else if (!r_ready[r_head]) begin
                    // a store waiting at the head asks to graduate
                    if (x_cls == CLS_STORE) begin
                        n_res.outcome   = OUTC_GRADUATE;
                        n_res.out_index = to_index(r_head);
                    end else begin
                        n_res.outcome = OUTC_NONE;
                    end
                end else begin
                    n_ready[r_head] = 1'b0;
                    n_head          = next_slot(r_head);
                    n_full          = 1'b0;
                    // taken branch replaces the incremented pc
                    if (x_cls == CLS_BRANCH && r_rd_value != NOT_TAKEN) begin
                        n_pc = r_rd_value;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                    n_res.reg_write = (x_cls == CLS_ALU || x_cls == CLS_LOAD)
                                      && (32'(x_dest) < NUM_REGS);
                    n_res.clear_mem_status = (x_cls == CLS_LOAD || x_cls == CLS_STORE);
                    n_res.outcome   = OUTC_RETIRED;
                    n_res.out_index = to_index(r_head);
                    n_res.out_dest  = x_dest;
                    n_res.out_value = r_rd_value;
                end
            end
            default: begin
                // unused operation codes leave everything as it is
            end
        endcase

        n_res.is_full  = n_full;
        n_res.pc_value = n_pc;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_full    <= 1'b0;
            r_pc      <= '0;
            r_ready   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state <= S_EXEC;
            end else if (fire) begin
                r_state <= S_IDLE;
            end
            if (fire) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_full    <= n_full;
                r_pc      <= n_pc;
                r_ready   <= n_ready;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op   <= s_op;
            r_idx  <= s_idx;
            r_dest <= s_dest;
            r_cls  <= s_cls;
            r_wval <= s_val;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    // entry memories: read on accept, written back in the execute cycle
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd_value <= m_value[s_rd_addr];
            r_rd_info  <= m_info[s_rd_addr];
        end
        if (fire && x_value_we) begin
            m_value[x_addr] <= r_wval;
        end
        if (fire && x_info_we) begin
            m_info[r_tail] <= {r_dest, r_cls};
        end
    end

    // result stream
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_res.outcome;
    assign o_m_axis_tdata  = {3'b000,
                              r_res.flush_last,
                              r_res.flush_first,
                              r_res.flush_any,
                              r_res.clear_mem_status,
                              r_res.pc_value,
                              r_res.value_ready,
                              r_res.out_value,
                              r_res.out_dest,
                              r_res.reg_write,
                              r_res.is_full,
                              r_res.out_index};

endmodule
